// ----- design/cvem_pkg.sv -----
// Package for the cell voltage extremes monitor.
// Holds field widths, reset values, register indexes and the frame snapshot type.
// No dependencies.
package cvem_pkg;

   localparam int MV_W       = 16;
   localparam int POS_W      = 7;
   localparam int IDX_W      = 8;
   localparam int SUM_W      = 22;
   localparam int REP_IDX_W  = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int CELL_COUNT_DEF   = 16;
   localparam int STORED_CELLS_DEF = 16;
   localparam int INDEX_CLAMP_DEF  = 255;

   localparam logic [MV_W-1:0]  CELL_LOW_RST    = 16'd1000;
   localparam logic [MV_W-1:0]  CELL_HIGH_RST   = 16'd6000;
   localparam logic [MV_W-1:0]  STATUS_CODE_RST = 16'h0069;
   localparam logic [POS_W-1:0] MAX_CELLS_RST   = 7'd8;

   // Pack rescale: raw limit, scale factor and the 90 to 110 percent band.
   localparam int RESCALE_RAW_MAX = 6553;
   localparam int RESCALE_FACTOR  = 10;
   localparam int BAND_LO_NUM     = 9;
   localparam int BAND_HI_NUM     = 11;
   localparam int CHECK_W         = 27;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CELL_LOW    = 2'd0,
      CSR_CELL_HIGH   = 2'd1,
      CSR_STATUS_CODE = 2'd2,
      CSR_MAX_CELLS   = 2'd3
   } csr_index_type;

   // Everything the summary needs, captured when the last item of a frame is taken.
   typedef struct packed {
      logic [MV_W-1:0]      run_min_mv;
      logic [MV_W-1:0]      run_max_mv;
      logic [POS_W-1:0]     run_min_pos;
      logic [POS_W-1:0]     run_max_pos;
      logic [POS_W-1:0]     valid_count;
      logic [POS_W-1:0]     stored_count;
      logic [SUM_W-1:0]     cell_sum;
      logic                 pack_present;
      logic [MV_W-1:0]      pack_raw;
      logic                 status_present;
      logic                 status_ok;
      logic                 rep_present;
      logic [MV_W-1:0]      rep_min_mv;
      logic [MV_W-1:0]      rep_max_mv;
      logic [REP_IDX_W-1:0] rep_min_idx;
      logic [REP_IDX_W-1:0] rep_max_idx;
   } snap_type;

   typedef struct packed {
      logic              extremes_valid;
      logic [MV_W-1:0]   min_cell_mv;
      logic [MV_W-1:0]   max_cell_mv;
      logic [IDX_W-1:0]  min_cell_index;
      logic [IDX_W-1:0]  max_cell_index;
      logic [POS_W-1:0]  valid_cell_count;
      logic [POS_W-1:0]  stored_cell_count;
      logic              pack_valid;
      logic [MV_W-1:0]   pack_voltage_cv;
      logic              any_data;
   } summary_type;

endpackage

// ----- design/cvem_summary.sv -----
// Summary stage of the cell voltage extremes monitor: a snapshot register, the
// extremes selection and pack rescale check, and the result register.
// Depends on cvem_pkg.
module cvem_summary #(
   parameter int unsigned INDEX_CLAMP = cvem_pkg::INDEX_CLAMP_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          snap_load,
   input  cvem_pkg::snap_type            snap_data,
   output logic                          snap_ready,
   input  logic [cvem_pkg::POS_W-1:0]    max_cells,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cvem_pkg::summary_type         rsp_data
);
   import cvem_pkg::*;

   logic        snap_valid_ff, snap_valid_in;
   snap_type    snap_ff, snap_in;
   logic        rsp_valid_ff, rsp_valid_in;
   summary_type rsp_ff, rsp_in;
   summary_type sum_calc;
   logic        out_ready;

   logic [CHECK_W-1:0] sum_lo, sum_hi, raw_x100;
   logic [MV_W-1:0]    raw_x10;
   logic               rescale_ok;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign snap_ready = !snap_valid_ff || out_ready;

   always_comb begin
      snap_valid_in = snap_valid_ff;
      snap_in       = snap_ff;
      if (snap_load) begin
         snap_valid_in = 1'b1;
         snap_in       = snap_data;
      end else if (out_ready) begin
         snap_valid_in = 1'b0;
      end
   end

   // floor(sum*9/10) <= raw*10 is the same as sum*9 <= raw*100 + 9, and
   // raw*10 <= floor(sum*11/10) is the same as raw*100 <= sum*11.
   always_comb begin
      sum_lo   = CHECK_W'(snap_ff.cell_sum) * CHECK_W'(BAND_LO_NUM);
      sum_hi   = CHECK_W'(snap_ff.cell_sum) * CHECK_W'(BAND_HI_NUM);
      raw_x100 = CHECK_W'(snap_ff.pack_raw) * CHECK_W'(RESCALE_FACTOR * RESCALE_FACTOR);
      raw_x10  = MV_W'(snap_ff.pack_raw * MV_W'(RESCALE_FACTOR));
      rescale_ok = (snap_ff.pack_raw != '0)
                && (snap_ff.pack_raw <= MV_W'(RESCALE_RAW_MAX))
                && snap_ff.status_ok
                && (snap_ff.valid_count != '0)
                && (snap_ff.valid_count <= max_cells)
                && (sum_lo <= raw_x100 + CHECK_W'(BAND_LO_NUM))
                && (raw_x100 <= sum_hi);
   end

   always_comb begin
      sum_calc = '0;
      if (snap_ff.rep_present) begin
         sum_calc.extremes_valid = 1'b1;
         sum_calc.min_cell_mv    = snap_ff.rep_min_mv;
         sum_calc.max_cell_mv    = snap_ff.rep_max_mv;
         sum_calc.min_cell_index = (snap_ff.rep_min_idx > REP_IDX_W'(INDEX_CLAMP))
                                 ? IDX_W'(INDEX_CLAMP) : snap_ff.rep_min_idx[IDX_W-1:0];
         sum_calc.max_cell_index = (snap_ff.rep_max_idx > REP_IDX_W'(INDEX_CLAMP))
                                 ? IDX_W'(INDEX_CLAMP) : snap_ff.rep_max_idx[IDX_W-1:0];
      end else if (snap_ff.valid_count != '0) begin
         sum_calc.extremes_valid = 1'b1;
         sum_calc.min_cell_mv    = snap_ff.run_min_mv;
         sum_calc.max_cell_mv    = snap_ff.run_max_mv;
         sum_calc.min_cell_index = IDX_W'(snap_ff.run_min_pos);
         sum_calc.max_cell_index = IDX_W'(snap_ff.run_max_pos);
      end
      sum_calc.valid_cell_count  = snap_ff.valid_count;
      sum_calc.stored_cell_count = snap_ff.stored_count;
      sum_calc.pack_valid        = snap_ff.pack_present;
      if (snap_ff.pack_present) begin
         sum_calc.pack_voltage_cv = rescale_ok ? raw_x10 : snap_ff.pack_raw;
      end
      sum_calc.any_data = sum_calc.extremes_valid || (snap_ff.stored_count != '0)
                       || snap_ff.pack_present || snap_ff.status_present;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = snap_valid_ff;
         if (snap_valid_ff) begin
            rsp_in = sum_calc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/cell_voltage_extremes_monitor_unit.sv -----
// Top level of the cell voltage extremes monitor: configuration registers and
// the per-frame accumulator. Depends on cvem_pkg and cvem_summary.
//
// Takes one cell reading per item, every cycle. Readings inside the
// [cell_low_mv, cell_high_mv] window update a running minimum, maximum, count
// and sum; the item flagged last closes the frame. Its summary reaches the rsp_
// port through the snapshot register, which loads when that item is accepted,
// and then the result register. The frame state is cleared on that same accept,
// so the next frame may start right behind it.
// Input is stalled only when the snapshot register and the result register both
// hold a summary and rsp_stall is high.
// Write the configuration registers only while no frame is in flight.
module cell_voltage_extremes_monitor_unit #(
   parameter int unsigned CELL_COUNT   = cvem_pkg::CELL_COUNT_DEF,
   parameter int unsigned STORED_CELLS = cvem_pkg::STORED_CELLS_DEF,
   parameter int unsigned INDEX_CLAMP  = cvem_pkg::INDEX_CLAMP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_wen,
   input  logic [cvem_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [cvem_pkg::CSR_DATA_W-1:0]  csr_wdata,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cell_present,
   input  logic [cvem_pkg::MV_W-1:0]        req_cell_mv,
   input  logic                             req_last_cell,
   input  logic                             req_pack_present,
   input  logic [cvem_pkg::MV_W-1:0]        req_pack_raw,
   input  logic                             req_status_present,
   input  logic [cvem_pkg::MV_W-1:0]        req_status_word,
   input  logic                             req_reported_present,
   input  logic [cvem_pkg::MV_W-1:0]        req_reported_min_mv,
   input  logic [cvem_pkg::MV_W-1:0]        req_reported_max_mv,
   input  logic [cvem_pkg::REP_IDX_W-1:0]   req_reported_min_index,
   input  logic [cvem_pkg::REP_IDX_W-1:0]   req_reported_max_index,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_extremes_valid,
   output logic [cvem_pkg::MV_W-1:0]        rsp_min_cell_mv,
   output logic [cvem_pkg::MV_W-1:0]        rsp_max_cell_mv,
   output logic [cvem_pkg::IDX_W-1:0]       rsp_min_cell_index,
   output logic [cvem_pkg::IDX_W-1:0]       rsp_max_cell_index,
   output logic [cvem_pkg::POS_W-1:0]       rsp_valid_cell_count,
   output logic [cvem_pkg::POS_W-1:0]       rsp_stored_cell_count,
   output logic                             rsp_pack_valid,
   output logic [cvem_pkg::MV_W-1:0]        rsp_pack_voltage_cv,
   output logic                             rsp_any_data
);
   import cvem_pkg::*;

   logic [MV_W-1:0]  cell_low_ff, cell_low_in;
   logic [MV_W-1:0]  cell_high_ff, cell_high_in;
   logic [MV_W-1:0]  status_code_ff, status_code_in;
   logic [POS_W-1:0] max_cells_ff, max_cells_in;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [MV_W-1:0]  min_mv_ff, min_mv_in;
   logic [MV_W-1:0]  max_mv_ff, max_mv_in;
   logic [POS_W-1:0] min_pos_ff, min_pos_in;
   logic [POS_W-1:0] max_pos_ff, max_pos_in;
   logic [POS_W-1:0] vcount_ff, vcount_in;
   logic [POS_W-1:0] stored_ff, stored_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [POS_W-1:0] pos_upd, min_pos_upd, max_pos_upd, vcount_upd, stored_upd;
   logic [MV_W-1:0]  min_mv_upd, max_mv_upd;
   logic [SUM_W-1:0] sum_upd;
   logic             in_frame, cell_ok, accept, snap_ready;
   snap_type         snap;
   summary_type      rsp_data;

   always_comb begin
      cell_low_in    = cell_low_ff;
      cell_high_in   = cell_high_ff;
      status_code_in = status_code_ff;
      max_cells_in   = max_cells_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_CELL_LOW:    cell_low_in    = csr_wdata;
            CSR_CELL_HIGH:   cell_high_in   = csr_wdata;
            CSR_STATUS_CODE: status_code_in = csr_wdata;
            CSR_MAX_CELLS:   max_cells_in   = csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = !snap_ready;
   assign accept    = req_valid && snap_ready;

   // Positions past the cell count are ignored and the position holds there.
   always_comb begin
      in_frame    = pos_ff < POS_W'(CELL_COUNT);
      pos_upd     = pos_ff;
      min_mv_upd  = min_mv_ff;
      max_mv_upd  = max_mv_ff;
      min_pos_upd = min_pos_ff;
      max_pos_upd = max_pos_ff;
      vcount_upd  = vcount_ff;
      stored_upd  = stored_ff;
      sum_upd     = sum_ff;
      cell_ok     = in_frame && req_cell_present
                 && (req_cell_mv >= cell_low_ff) && (req_cell_mv <= cell_high_ff);
      if (in_frame) begin
         pos_upd = pos_ff + POS_W'(1);
      end
      if (cell_ok) begin
         if (pos_ff < POS_W'(STORED_CELLS)) begin
            stored_upd = pos_upd;
         end
         vcount_upd = vcount_ff + POS_W'(1);
         sum_upd    = sum_ff + SUM_W'(req_cell_mv);
         // Strict compares keep the first position on ties.
         if (req_cell_mv < min_mv_ff) begin
            min_mv_upd  = req_cell_mv;
            min_pos_upd = pos_upd;
         end
         if (req_cell_mv > max_mv_ff) begin
            max_mv_upd  = req_cell_mv;
            max_pos_upd = pos_upd;
         end
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      min_mv_in  = min_mv_ff;
      max_mv_in  = max_mv_ff;
      min_pos_in = min_pos_ff;
      max_pos_in = max_pos_ff;
      vcount_in  = vcount_ff;
      stored_in  = stored_ff;
      sum_in     = sum_ff;
      if (accept) begin
         if (req_last_cell) begin
            pos_in     = '0;
            min_mv_in  = '1;
            max_mv_in  = '0;
            min_pos_in = '0;
            max_pos_in = '0;
            vcount_in  = '0;
            stored_in  = '0;
            sum_in     = '0;
         end else begin
            pos_in     = pos_upd;
            min_mv_in  = min_mv_upd;
            max_mv_in  = max_mv_upd;
            min_pos_in = min_pos_upd;
            max_pos_in = max_pos_upd;
            vcount_in  = vcount_upd;
            stored_in  = stored_upd;
            sum_in     = sum_upd;
         end
      end
   end

   always_comb begin
      snap.run_min_mv     = min_mv_upd;
      snap.run_max_mv     = max_mv_upd;
      snap.run_min_pos    = min_pos_upd;
      snap.run_max_pos    = max_pos_upd;
      snap.valid_count    = vcount_upd;
      snap.stored_count   = stored_upd;
      snap.cell_sum       = sum_upd;
      snap.pack_present   = req_pack_present;
      snap.pack_raw       = req_pack_raw;
      snap.status_present = req_status_present;
      snap.status_ok      = req_status_present && (req_status_word == status_code_ff);
      snap.rep_present    = req_reported_present;
      snap.rep_min_mv     = req_reported_min_mv;
      snap.rep_max_mv     = req_reported_max_mv;
      snap.rep_min_idx    = req_reported_min_index;
      snap.rep_max_idx    = req_reported_max_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_low_ff    <= CELL_LOW_RST;
         cell_high_ff   <= CELL_HIGH_RST;
         status_code_ff <= STATUS_CODE_RST;
         max_cells_ff   <= MAX_CELLS_RST;
         pos_ff         <= '0;
         min_mv_ff      <= '1;
         max_mv_ff      <= '0;
         min_pos_ff     <= '0;
         max_pos_ff     <= '0;
         vcount_ff      <= '0;
         stored_ff      <= '0;
         sum_ff         <= '0;
      end else begin
         cell_low_ff    <= cell_low_in;
         cell_high_ff   <= cell_high_in;
         status_code_ff <= status_code_in;
         max_cells_ff   <= max_cells_in;
         pos_ff         <= pos_in;
         min_mv_ff      <= min_mv_in;
         max_mv_ff      <= max_mv_in;
         min_pos_ff     <= min_pos_in;
         max_pos_ff     <= max_pos_in;
         vcount_ff      <= vcount_in;
         stored_ff      <= stored_in;
         sum_ff         <= sum_in;
      end
   end

   cvem_summary #(
      .INDEX_CLAMP (INDEX_CLAMP)
   ) u_summary (
      .clock      (clock),
      .reset      (reset),
      .snap_load  (accept && req_last_cell),
      .snap_data  (snap),
      .snap_ready (snap_ready),
      .max_cells  (max_cells_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_extremes_valid    = rsp_data.extremes_valid;
   assign rsp_min_cell_mv       = rsp_data.min_cell_mv;
   assign rsp_max_cell_mv       = rsp_data.max_cell_mv;
   assign rsp_min_cell_index    = rsp_data.min_cell_index;
   assign rsp_max_cell_index    = rsp_data.max_cell_index;
   assign rsp_valid_cell_count  = rsp_data.valid_cell_count;
   assign rsp_stored_cell_count = rsp_data.stored_cell_count;
   assign rsp_pack_valid        = rsp_data.pack_valid;
   assign rsp_pack_voltage_cv   = rsp_data.pack_voltage_cv;
   assign rsp_any_data          = rsp_data.any_data;

`ifndef ASSERT_OFF
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_cell |=> pos_ff == '0 && vcount_ff == '0 && sum_ff == '0)
      else $error("frame state not cleared after the last item");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_valid_cell_count <= POS_W'(CELL_COUNT)
                 && rsp_stored_cell_count <= POS_W'(STORED_CELLS)
                 && rsp_stored_cell_count <= POS_W'(CELL_COUNT))
      else $error("cell counts exceed the frame size");

   a_no_extremes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_extremes_valid |-> rsp_min_cell_mv == '0 && rsp_max_cell_mv == '0
                 && rsp_min_cell_index == '0 && rsp_max_cell_index == '0)
      else $error("extremes reported without a source");

   a_pack_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pack_valid |-> rsp_pack_voltage_cv == '0)
      else $error("pack voltage reported without a pack reading");
`endif

endmodule

// ----- bench/tb_cell_voltage_extremes_monitor_unit.sv -----
// Self-checking testbench for cell_voltage_extremes_monitor_unit: directed frames,
// register extremes and long random frame streams with random idling on both sides.
// Depends on cvem_pkg and the monitor RTL; every result is checked against an in-bench predictor.
module tb_cell_voltage_extremes_monitor_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import cvem_pkg::*;

   localparam int CELLS        = CELL_COUNT_DEF;
   localparam int STORED       = STORED_CELLS_DEF;
   localparam int CLAMP        = INDEX_CLAMP_DEF;
   localparam int DRAIN_CYCLES = 4;
   localparam int END_CYCLES   = 10;
   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 1820;

   typedef struct packed {
      logic                 cell_present;
      logic [MV_W-1:0]      cell_mv;
      logic                 is_last;
      logic                 pack_present;
      logic [MV_W-1:0]      pack_raw;
      logic                 status_present;
      logic [MV_W-1:0]      status_word;
      logic                 rep_present;
      logic [MV_W-1:0]      rep_min_mv;
      logic [MV_W-1:0]      rep_max_mv;
      logic [REP_IDX_W-1:0] rep_min_idx;
      logic [REP_IDX_W-1:0] rep_max_idx;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_wen   = 1'b0;
   csr_index_type         csr_index = CSR_CELL_LOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                 req_valid              = 1'b0;
   logic                 req_stall;
   logic                 req_cell_present       = 1'b0;
   logic [MV_W-1:0]      req_cell_mv            = '0;
   logic                 req_last_cell          = 1'b0;
   logic                 req_pack_present       = 1'b0;
   logic [MV_W-1:0]      req_pack_raw           = '0;
   logic                 req_status_present     = 1'b0;
   logic [MV_W-1:0]      req_status_word        = '0;
   logic                 req_reported_present   = 1'b0;
   logic [MV_W-1:0]      req_reported_min_mv    = '0;
   logic [MV_W-1:0]      req_reported_max_mv    = '0;
   logic [REP_IDX_W-1:0] req_reported_min_index = '0;
   logic [REP_IDX_W-1:0] req_reported_max_index = '0;

   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_extremes_valid;
   logic [MV_W-1:0]  rsp_min_cell_mv;
   logic [MV_W-1:0]  rsp_max_cell_mv;
   logic [IDX_W-1:0] rsp_min_cell_index;
   logic [IDX_W-1:0] rsp_max_cell_index;
   logic [POS_W-1:0] rsp_valid_cell_count;
   logic [POS_W-1:0] rsp_stored_cell_count;
   logic             rsp_pack_valid;
   logic [MV_W-1:0]  rsp_pack_voltage_cv;
   logic             rsp_any_data;

   // Register copies and the frame accumulator of the predictor.
   logic [MV_W-1:0]  cfg_low       = CELL_LOW_RST;
   logic [MV_W-1:0]  cfg_high      = CELL_HIGH_RST;
   logic [MV_W-1:0]  cfg_code      = STATUS_CODE_RST;
   logic [POS_W-1:0] cfg_max_cells = MAX_CELLS_RST;

   logic [POS_W-1:0] frame_pos;
   logic [MV_W-1:0]  frame_min;
   logic [MV_W-1:0]  frame_max;
   logic [POS_W-1:0] frame_min_pos;
   logic [POS_W-1:0] frame_max_pos;
   logic [POS_W-1:0] frame_valid;
   logic [POS_W-1:0] frame_stored;
   logic [SUM_W-1:0] frame_sum;

   summary_type summary_q[$];
   summary_type want;

   int  mismatch_count = 0;
   int  items_sent     = 0;
   int  idle_cycles    = 0;
   bit  req_idle_on    = 1'b1;
   bit  rsp_idle_on    = 1'b1;
   int  stall_left     = 0;
   bit  stall_hold     = 1'b0;

   cell_voltage_extremes_monitor_unit #(
      .CELL_COUNT   (CELLS),
      .STORED_CELLS (STORED),
      .INDEX_CLAMP  (CLAMP)
   ) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wen                (csr_wen),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_cell_present       (req_cell_present),
      .req_cell_mv            (req_cell_mv),
      .req_last_cell          (req_last_cell),
      .req_pack_present       (req_pack_present),
      .req_pack_raw           (req_pack_raw),
      .req_status_present     (req_status_present),
      .req_status_word        (req_status_word),
      .req_reported_present   (req_reported_present),
      .req_reported_min_mv    (req_reported_min_mv),
      .req_reported_max_mv    (req_reported_max_mv),
      .req_reported_min_index (req_reported_min_index),
      .req_reported_max_index (req_reported_max_index),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_extremes_valid     (rsp_extremes_valid),
      .rsp_min_cell_mv        (rsp_min_cell_mv),
      .rsp_max_cell_mv        (rsp_max_cell_mv),
      .rsp_min_cell_index     (rsp_min_cell_index),
      .rsp_max_cell_index     (rsp_max_cell_index),
      .rsp_valid_cell_count   (rsp_valid_cell_count),
      .rsp_stored_cell_count  (rsp_stored_cell_count),
      .rsp_pack_valid         (rsp_pack_valid),
      .rsp_pack_voltage_cv    (rsp_pack_voltage_cv),
      .rsp_any_data           (rsp_any_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void restart_frame();
      frame_pos     = '0;
      frame_min     = '1;
      frame_max     = '0;
      frame_min_pos = '0;
      frame_max_pos = '0;
      frame_valid   = '0;
      frame_stored  = '0;
      frame_sum     = '0;
   endfunction

   function automatic bit in_window(logic [MV_W-1:0] mv);
      return mv >= cfg_low && mv <= cfg_high;
   endfunction

   // Tenfold rescale for packs that report in tenths of a volt; the scaled value must
   // fall within 90 to 110 percent of the cell sum.
   function automatic logic [MV_W-1:0] pack_centivolts(logic [MV_W-1:0] raw, bit status_ok);
      longint unsigned scaled;
      longint unsigned band_lo;
      longint unsigned band_hi;
      scaled  = longint'(raw) * RESCALE_FACTOR;
      band_lo = longint'(frame_sum) * BAND_LO_NUM / 10;
      band_hi = longint'(frame_sum) * BAND_HI_NUM / 10;
      if (raw == 0 || raw > RESCALE_RAW_MAX || !status_ok) return raw;
      if (frame_valid == 0 || frame_valid > cfg_max_cells) return raw;
      if (scaled >= band_lo && scaled <= band_hi) return scaled[MV_W-1:0];
      return raw;
   endfunction

   function automatic logic [IDX_W-1:0] clamp_index(logic [REP_IDX_W-1:0] idx);
      return (idx > CLAMP) ? IDX_W'(CLAMP) : idx[IDX_W-1:0];
   endfunction

   function automatic void accumulate_reading(reading_type r);
      logic [POS_W-1:0] pos;
      summary_type      s;
      bit               status_ok;
      if (frame_pos < CELLS) begin
         pos = frame_pos + POS_W'(1);
         if (r.cell_present && in_window(r.cell_mv)) begin
            if (frame_pos < STORED) frame_stored = pos;
            frame_valid = frame_valid + POS_W'(1);
            frame_sum   = frame_sum + SUM_W'(r.cell_mv);
            // Strict compares: ties keep the first position.
            if (r.cell_mv < frame_min) begin
               frame_min     = r.cell_mv;
               frame_min_pos = pos;
            end
            if (r.cell_mv > frame_max) begin
               frame_max     = r.cell_mv;
               frame_max_pos = pos;
            end
         end
         frame_pos = pos;
      end
      if (!r.is_last) return;

      s = '0;
      status_ok = r.status_present && r.status_word == cfg_code;
      if (r.rep_present) begin
         s.extremes_valid = 1'b1;
         s.min_cell_mv    = r.rep_min_mv;
         s.max_cell_mv    = r.rep_max_mv;
         s.min_cell_index = clamp_index(r.rep_min_idx);
         s.max_cell_index = clamp_index(r.rep_max_idx);
      end else if (frame_valid > 0) begin
         s.extremes_valid = 1'b1;
         s.min_cell_mv    = frame_min;
         s.max_cell_mv    = frame_max;
         s.min_cell_index = {1'b0, frame_min_pos};
         s.max_cell_index = {1'b0, frame_max_pos};
      end
      s.valid_cell_count  = frame_valid;
      s.stored_cell_count = frame_stored;
      s.pack_valid        = r.pack_present;
      s.pack_voltage_cv   = r.pack_present ? pack_centivolts(r.pack_raw, status_ok) : '0;
      s.any_data          = s.extremes_valid || frame_stored > 0 || r.pack_present ||
                            r.status_present;
      summary_q.push_back(s);
      restart_frame();
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (summary_q.size() == 0) begin
            report_mismatch("summary received with none pending");
         end else begin
            want = summary_q.pop_front();
            check_field("extremes_valid", 32'(rsp_extremes_valid),
                        32'(want.extremes_valid));
            check_field("min_cell_mv", 32'(rsp_min_cell_mv), 32'(want.min_cell_mv));
            check_field("max_cell_mv", 32'(rsp_max_cell_mv), 32'(want.max_cell_mv));
            check_field("min_cell_index", 32'(rsp_min_cell_index),
                        32'(want.min_cell_index));
            check_field("max_cell_index", 32'(rsp_max_cell_index),
                        32'(want.max_cell_index));
            check_field("valid_cell_count", 32'(rsp_valid_cell_count),
                        32'(want.valid_cell_count));
            check_field("stored_cell_count", 32'(rsp_stored_cell_count),
                        32'(want.stored_cell_count));
            check_field("pack_valid", 32'(rsp_pack_valid), 32'(want.pack_valid));
            check_field("pack_voltage_cv", 32'(rsp_pack_voltage_cv),
                        32'(want.pack_voltage_cv));
            check_field("any_data", 32'(rsp_any_data), 32'(want.any_data));
         end
      end
   end

   // Ends the run when neither side has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- idling

   function automatic int stall_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
   endfunction

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!req_idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_hold = rsp_idle_on && ($urandom_range(0, 99) < 35);
         stall_left = stall_hold ? stall_len() : $urandom_range(1, 6);
      end
      stall_left--;
      rsp_stall <= stall_hold;
   end

   // ---------------------------------------------------------------- driving

   task automatic send_reading(reading_type r);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_cell_present       <= r.cell_present;
      req_cell_mv            <= r.cell_mv;
      req_last_cell          <= r.is_last;
      req_pack_present       <= r.pack_present;
      req_pack_raw           <= r.pack_raw;
      req_status_present     <= r.status_present;
      req_status_word        <= r.status_word;
      req_reported_present   <= r.rep_present;
      req_reported_min_mv    <= r.rep_min_mv;
      req_reported_max_mv    <= r.rep_max_mv;
      req_reported_min_index <= r.rep_min_idx;
      req_reported_max_index <= r.rep_max_idx;
      do @(posedge clock); while (req_stall);
      // Readings past the cell count are dropped by the block and do not count.
      if (frame_pos < CELLS || r.is_last) items_sent++;
      accumulate_reading(r);
   endtask

   // Drops valid and waits until every pending summary has come back.
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (summary_q.size() != 0);
   endtask

   task automatic apply_settings(logic [MV_W-1:0] lo, logic [MV_W-1:0] hi,
                                 logic [MV_W-1:0] code, logic [POS_W-1:0] max_cells);
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_CELL_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_CELL_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_STATUS_CODE;
      csr_wdata <= code;
      @(posedge clock);
      csr_index <= CSR_MAX_CELLS;
      csr_wdata <= CSR_DATA_W'(max_cells);
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_low       = lo;
      cfg_high      = hi;
      cfg_code      = code;
      cfg_max_cells = max_cells;
   endtask

   function automatic reading_type cell_reading(bit present, logic [MV_W-1:0] mv, bit is_last);
      reading_type r;
      r = '0;
      r.cell_present = present;
      r.cell_mv      = mv;
      r.is_last      = is_last;
      return r;
   endfunction

   function automatic reading_type last_with_pack(logic [MV_W-1:0] mv, logic [MV_W-1:0] raw,
                                                  logic [MV_W-1:0] status);
      reading_type r;
      r = cell_reading(1'b1, mv, 1'b1);
      r.pack_present   = 1'b1;
      r.pack_raw       = raw;
      r.status_present = 1'b1;
      r.status_word    = status;
      return r;
   endfunction

   function automatic logic [MV_W-1:0] random_cell_mv();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return MV_W'($urandom_range(cfg_low, cfg_high));
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return cfg_low;
            1: return cfg_high;
            2: return cfg_low - 1'b1;
            default: return cfg_high + 1'b1;
         endcase
      end
      return MV_W'($urandom());
   endfunction

   // Fields that only matter on the last item are filled with noise on every item.
   function automatic reading_type random_reading();
      reading_type r;
      r = reading_type'({$urandom(), $urandom(), $urandom(), $urandom(), 9'($urandom())});
      r.is_last = 1'b0;
      return r;
   endfunction

   // One frame of random readings; the last item often carries a pack voltage close to
   // a tenth of the cell sum so that the rescale band is exercised from both sides.
   task automatic random_frame(bit pause_mid);
      int          len;
      int          r;
      int          target;
      int unsigned sum_after;
      reading_type it;
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, CELLS);
      else             len = $urandom_range(CELLS + 1, CELLS + 6);
      for (int i = 1; i <= len; i++) begin
         it = random_reading();
         it.cell_present = $urandom_range(0, 99) >= 8;
         it.cell_mv      = random_cell_mv();
         if (i == len) begin
            it.is_last        = 1'b1;
            it.pack_present   = $urandom_range(0, 99) < 85;
            it.status_present = $urandom_range(0, 99) < 80;
            it.rep_present    = $urandom_range(0, 99) < 30;
            if ($urandom_range(0, 99) < 70) it.status_word = cfg_code;
            if ($urandom_range(0, 1)) it.rep_min_idx = REP_IDX_W'($urandom_range(0, 300));
            if ($urandom_range(0, 1)) it.rep_max_idx = REP_IDX_W'($urandom_range(0, 300));
            sum_after = 32'(frame_sum);
            if (frame_pos < CELLS && it.cell_present && in_window(it.cell_mv))
               sum_after += 32'(it.cell_mv);
            r = $urandom_range(0, 99);
            if (r < 55) begin
               target = int'(sum_after / 10) + int'($urandom_range(0, 30)) - 15;
               if (target < 0) target = 0;
               if (target > 16'hFFFF) target = 16'hFFFF;
               it.pack_raw = MV_W'(target);
            end else if (r < 75) begin
               it.pack_raw = MV_W'($urandom_range(0, RESCALE_RAW_MAX + 500));
            end
         end
         if (pause_mid && i == len / 2 + 1) wait_results();
         send_reading(it);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Power-on register values: window edges, ties, reported extremes, pack rescale band.
   task automatic test_reset_values();
      logic [MV_W-1:0] band_raw[4] = '{16'd450, 16'd550, 16'd449, 16'd551};
      reading_type     it;
      send_reading(cell_reading(1'b0, 16'd0, 1'b1));
      send_reading(cell_reading(1'b1, 16'd1000, 1'b0));
      send_reading(cell_reading(1'b1, 16'd999, 1'b0));
      send_reading(cell_reading(1'b1, 16'd6000, 1'b0));
      send_reading(cell_reading(1'b1, 16'd6001, 1'b0));
      send_reading(cell_reading(1'b0, 16'd3000, 1'b0));
      send_reading(cell_reading(1'b1, 16'd1000, 1'b0));
      send_reading(cell_reading(1'b1, 16'd6000, 1'b0));
      send_reading(cell_reading(1'b1, 16'd0, 1'b0));
      send_reading(cell_reading(1'b1, 16'hFFFF, 1'b0));
      send_reading(last_with_pack(16'd2000, 16'd1600, STATUS_CODE_RST));

      // Reported extremes win; indices above the clamp saturate.
      it = last_with_pack(16'd3000, MV_W'(RESCALE_RAW_MAX), STATUS_CODE_RST + 1'b1);
      it.cell_present = 1'b0;
      it.rep_present  = 1'b1;
      it.rep_min_mv   = 16'd0;
      it.rep_max_mv   = 16'hFFFF;
      it.rep_min_idx  = 16'd300;
      it.rep_max_idx  = REP_IDX_W'(CLAMP);
      send_reading(it);

      send_reading(last_with_pack(16'd5000, MV_W'(RESCALE_RAW_MAX + 1), STATUS_CODE_RST));
      send_reading(last_with_pack(16'd5000, 16'd0, STATUS_CODE_RST));
      foreach (band_raw[k]) send_reading(last_with_pack(16'd5000, band_raw[k], STATUS_CODE_RST));
      it = last_with_pack(16'd5000, 16'd500, STATUS_CODE_RST);
      it.status_present = 1'b0;
      send_reading(it);
   endtask

   // Full, inverted and single-value windows with extreme status codes and cell limits.
   task automatic test_register_extremes();
      apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 7'd64);
      // A full-scale reading never beats the reset minimum, so its position stays zero.
      send_reading(last_with_pack(16'hFFFF, MV_W'(RESCALE_RAW_MAX), 16'hFFFF));
      send_reading(cell_reading(1'b1, 16'd0, 1'b0));
      send_reading(cell_reading(1'b1, 16'hFFFF, 1'b0));
      send_reading(cell_reading(1'b1, 16'd0, 1'b0));
      send_reading(cell_reading(1'b1, 16'hFFFF, 1'b1));

      apply_settings(16'd5000, 16'd4000, 16'd0, 7'd0);
      send_reading(cell_reading(1'b1, 16'd4500, 1'b0));
      send_reading(cell_reading(1'b1, 16'd5000, 1'b0));
      send_reading(last_with_pack(16'd4000, 16'd450, 16'd0));

      apply_settings(16'd3000, 16'd3000, 16'd0, 7'd1);
      send_reading(last_with_pack(16'd3000, 16'd300, 16'd0));
      send_reading(cell_reading(1'b1, 16'd2999, 1'b0));
      send_reading(cell_reading(1'b1, 16'd3001, 1'b0));
      send_reading(cell_reading(1'b1, 16'd3000, 1'b0));
      send_reading(last_with_pack(16'd3000, 16'd600, 16'd0));
   endtask

   task automatic test_random_frames();
      int goal;
      int phase;
      int phase_end;
      int lo;
      goal  = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < goal) begin
         case (phase % 8)
            0: apply_settings(CELL_LOW_RST, CELL_HIGH_RST, STATUS_CODE_RST, MAX_CELLS_RST);
            1: apply_settings(16'd0, 16'hFFFF, MV_W'($urandom()),
                              POS_W'($urandom_range(0, 64)));
            2: begin
               lo = $urandom_range(0, 30000);
               apply_settings(MV_W'(lo), MV_W'(lo + int'($urandom_range(0, 30000))),
                              MV_W'($urandom()), POS_W'($urandom_range(0, 64)));
            end
            3: apply_settings(16'd500, 16'd8000, STATUS_CODE_RST, 7'd64);
            4: begin
               lo = $urandom_range(0, 16'hFFFF);
               apply_settings(MV_W'(lo), MV_W'(lo), MV_W'($urandom()),
                              POS_W'($urandom_range(0, 64)));
            end
            5: apply_settings(16'd1, 16'd7000, 16'd0, 7'd1);
            6: apply_settings(MV_W'($urandom_range(0, 2000)),
                              MV_W'($urandom_range(4000, 16'hFFFF)),
                              16'hFFFF, POS_W'($urandom_range(0, 16)));
            default: begin
               lo = $urandom_range(3000, 16'hFFFF);
               apply_settings(MV_W'(lo), MV_W'($urandom_range(0, lo - 1)),
                              MV_W'($urandom()), POS_W'($urandom_range(0, 64)));
            end
         endcase
         req_idle_on = (phase % 3) != 2;
         rsp_idle_on = (phase % 4) != 3;
         phase_end = items_sent + 150;
         // The first frame of the first phase halts halfway until every summary has drained.
         random_frame(phase == 0);
         while (items_sent < phase_end && items_sent < goal)
            random_frame($urandom_range(0, 39) == 0);
         phase++;
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      restart_frame();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_register_extremes();
      test_random_frames();

      wait_results();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
design/cvem_pkg.sv
design/cvem_summary.sv
design/cell_voltage_extremes_monitor_unit.sv
bench/tb_cell_voltage_extremes_monitor_unit.sv
